/* rtl/elt_pkg.sv */
package elt_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Index width and stored widths; the ports carry 32-bit keys and values.
  localparam int IDX_BITS = $clog2(ENTRIES);
  localparam int KEY_W    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VAL_W    = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  // Time that a reserved entry shows in every age comparison.
  localparam logic [31:0] RESERVED_TIME = 32'hff00_0000;

  typedef logic [IDX_BITS-1:0] idx_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [31:0]         time_t;

  typedef enum logic [2:0] {
    CMD_PUT        = 3'd0,
    CMD_PUT_RES    = 3'd1,
    CMD_GET        = 3'd2,
    CMD_REFRESH    = 3'd3,
    CMD_RESERVE    = 3'd4,
    CMD_RESET_TIME = 3'd5,
    CMD_REMOVE     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DECIDE
  } state_t;

  // Write request into the entry memories.
  typedef struct packed {
    logic  key_we;
    logic  val_we;
    logic  time_we;
    idx_t  addr;
    key_t  key;
    val_t  val;
    time_t tm;
  } elt_wr_t;

  // Registered read data from the entry memories.
  typedef struct packed {
    key_t  key;
    val_t  val;
    time_t tm;
  } elt_rd_t;

endpackage

/* rtl/elt_mem.sv */
module elt_mem (
  input  logic             clk,
  input  elt_pkg::elt_wr_t wr,
  input  elt_pkg::idx_t    rd_addr,
  output elt_pkg::elt_rd_t rd
);
  import elt_pkg::*;

  key_t  key_mem  [ENTRIES];
  val_t  val_mem  [ENTRIES];
  time_t time_mem [ENTRIES];

  // One write port, one registered read port per array.
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.addr] <= wr.key;
    end
    if (wr.val_we) begin
      val_mem[wr.addr] <= wr.val;
    end
    if (wr.time_we) begin
      time_mem[wr.addr] <= wr.tm;
    end
    rd.key <= key_mem[rd_addr];
    rd.val <= val_mem[rd_addr];
    rd.tm  <= time_mem[rd_addr];
  end

endmodule

/* rtl/expiring_lru_table.sv */
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------------
// config    | cfg_write               | cfg_data (expire_seconds)
// request   | in_valid / in_stall     | command, lookup_key, new_value, now
// result    | out_valid / out_stall   | status, slot, found_value, hits, misses
//
// A request is accepted, then every entry is streamed out of the single read
// port of the entry memories, the last entry is compared, and the decide step
// writes back.
// Reset (rst, synchronous) clears the valid and reserved marks, the counters,
// expire_seconds and the handshakes; entry memories are not cleared.
// A waiting result does not block the next request; the decide step holds only
// while the result register is still full and stalled.
module expiring_lru_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] lookup_key,
  input  logic [31:0] new_value,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  slot,
  output logic [31:0] found_value,
  output logic [31:0] hits,
  output logic [31:0] misses
);
  import elt_pkg::*;

  // Expiry test: the 33-bit sum never wraps.
  function automatic logic expired(input time_t t, input time_t life, input time_t at);
    logic [32:0] total;
    total = {1'b0, t} + {1'b0, life};
    return total <= {1'b0, at};
  endfunction

  state_t state, state_next;

  // Control state
  logic [31:0]        expire_seconds;
  logic [ENTRIES-1:0] entry_valid, entry_reserved;
  logic [31:0]        hit_counter, miss_counter;
  logic               cmp_vld;
  logic               match_found, empty_found;

  // Captured request
  cmd_t  cmd_q;
  key_t  key_q;
  val_t  val_q;
  time_t now_q;

  // Scan pointers and scan results
  idx_t  scan_idx, cmp_idx;
  idx_t  match_idx, empty_idx, old_idx;
  time_t match_eff, old_eff;
  logic  match_res;
  val_t  match_val;

  // Memory interface
  elt_wr_t wr;
  elt_rd_t rd;

  // Handshake and compare terms
  logic  in_take, go, scan_last;
  time_t cur_eff;
  logic  cur_match, cur_empty;

  // Decide step
  logic               put_have, tgt_res, get_hit;
  idx_t               put_tgt;
  status_t            res_status;
  idx_t               res_slot;
  val_t               res_val;
  logic [ENTRIES-1:0] valid_next, reserved_next;
  logic [31:0]        hit_next, miss_next;

  elt_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (scan_idx),
    .rd      (rd)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_stall   = (state != S_IDLE);
    in_take    = in_valid && !in_stall;
    // Decide only when the result register is free after this edge.
    go         = (state == S_DECIDE) && (!out_valid || !out_stall);
    scan_last  = (scan_idx == idx_t'(ENTRIES - 1));
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_take) state_next = S_SCAN;
      S_SCAN:   if (scan_last) state_next = S_LAST;
      S_LAST:   state_next = S_DECIDE;
      S_DECIDE: if (go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Scan compare: read data belongs to the address held in cmp_idx.
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_eff   = entry_reserved[cmp_idx] ? RESERVED_TIME : rd.tm;
    cur_match = entry_valid[cmp_idx] && (rd.key == key_q);
    cur_empty = !entry_valid[cmp_idx];
  end

  // ---------------------------------------------------------------------------
  // Decide: pick the target, build the write-back and the result.
  // ---------------------------------------------------------------------------
  always_comb begin
    // Put target: matching key, else first empty slot, else oldest if expired.
    if (match_found) begin
      put_tgt  = match_idx;
      put_have = 1'b1;
    end else if (empty_found) begin
      put_tgt  = empty_idx;
      put_have = 1'b1;
    end else begin
      put_tgt  = old_idx;
      put_have = expired(old_eff, expire_seconds, now_q);
    end
    tgt_res = entry_valid[put_tgt] && entry_reserved[put_tgt];
    get_hit = match_found &&
              ((expire_seconds == '0) || !expired(match_eff, expire_seconds, now_q));

    wr.key_we     = 1'b0;
    wr.val_we     = 1'b0;
    wr.time_we    = 1'b0;
    wr.addr       = match_idx;
    wr.key        = key_q;
    wr.val        = val_q;
    wr.tm         = now_q;
    valid_next    = entry_valid;
    reserved_next = entry_reserved;
    hit_next      = hit_counter;
    miss_next     = miss_counter;
    res_status    = ST_MISS;
    res_slot      = '0;
    res_val       = '0;

    unique case (cmd_q)
      CMD_PUT, CMD_PUT_RES: begin
        if (put_have) begin
          // A reserved entry stays reserved and keeps its time.
          wr.addr                = put_tgt;
          wr.key_we              = 1'b1;
          wr.val_we              = 1'b1;
          wr.time_we             = !tgt_res && (cmd_q == CMD_PUT);
          valid_next[put_tgt]    = 1'b1;
          reserved_next[put_tgt] = tgt_res || (cmd_q == CMD_PUT_RES);
          res_status             = ST_OK;
          res_slot               = put_tgt;
          res_val                = val_q;
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_GET: begin
        if (get_hit) begin
          wr.time_we = !match_res;
          hit_next   = hit_counter + 32'd1;
          res_status = ST_OK;
          res_slot   = match_idx;
          res_val    = match_val;
        end else begin
          miss_next = miss_counter + 32'd1;
        end
      end
      CMD_REFRESH, CMD_RESET_TIME: begin
        if (match_found) begin
          wr.time_we               = 1'b1;
          reserved_next[match_idx] = 1'b0;
          res_status               = ST_OK;
          res_slot                 = match_idx;
        end
      end
      CMD_RESERVE: begin
        if (match_found) begin
          reserved_next[match_idx] = 1'b1;
          res_status               = ST_OK;
          res_slot                 = match_idx;
        end
      end
      CMD_REMOVE: begin
        if (match_found) begin
          valid_next[match_idx]    = 1'b0;
          reserved_next[match_idx] = 1'b0;
          res_status               = ST_OK;
          res_slot                 = match_idx;
        end
      end
      default: begin
        // Unused code: report not found, change nothing.
      end
    endcase

    // Write back only in the cycle the decision is taken.
    if (!go) begin
      wr.key_we  = 1'b0;
      wr.val_we  = 1'b0;
      wr.time_we = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      expire_seconds <= '0;
      entry_valid    <= '0;
      entry_reserved <= '0;
      hit_counter    <= '0;
      miss_counter   <= '0;
      cmp_vld        <= 1'b0;
      match_found    <= 1'b0;
      empty_found    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        expire_seconds <= cfg_data;
      end
      cmp_vld <= (state == S_SCAN);
      if (in_take) begin
        match_found <= 1'b0;
        empty_found <= 1'b0;
      end else if (cmp_vld) begin
        if (cur_match) begin
          match_found <= 1'b1;
        end
        if (cur_empty) begin
          empty_found <= 1'b1;
        end
      end
      if (go) begin
        entry_valid    <= valid_next;
        entry_reserved <= reserved_next;
        hit_counter    <= hit_next;
        miss_counter   <= miss_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q    <= cmd_t'(command);
      key_q    <= lookup_key[KEY_W-1:0];
      val_q    <= new_value[VAL_W-1:0];
      now_q    <= now;
      scan_idx <= '0;
    end else if ((state == S_SCAN) && !scan_last) begin
      scan_idx <= scan_idx + 1'b1;
    end
    cmp_idx <= scan_idx;

    if (cmp_vld) begin
      // Keep the first match and the first hole.
      if (cur_match && !match_found) begin
        match_idx <= cmp_idx;
        match_eff <= cur_eff;
        match_res <= entry_reserved[cmp_idx];
        match_val <= rd.val;
      end
      if (cur_empty && !empty_found) begin
        empty_idx <= cmp_idx;
      end
      // Oldest: strict compare keeps the lowest index on a tie.
      if ((cmp_idx == '0) || (old_eff > cur_eff)) begin
        old_idx <= cmp_idx;
        old_eff <= cur_eff;
      end
    end

    if (go) begin
      status      <= res_status;
      slot        <= 6'(res_slot);
      found_value <= 32'(res_val);
    end
  end

  // Counters only move on the edge that loads a new result.
  assign hits   = hit_counter;
  assign misses = miss_counter;

endmodule

/* rtl/elt_check.sv */
module elt_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [5:0]  slot,
  input logic [31:0] found_value,
  input logic [31:0] hits,
  input logic [31:0] misses
);
  import elt_pkg::*;

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot) &&
    $stable(found_value) && $stable(hits) && $stable(misses))
    else $error("stalled result changed");

  // An accepted request keeps the block busy for the scan.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken during a scan");

  // A new result comes only out of a busy block.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request");

  // Status codes are in range.
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
    else $error("bad status code");

  // A failed request reports no slot and no value.
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (slot == '0) && (found_value == '0))
    else $error("failed request carries data");

endmodule

bind expiring_lru_table elt_check u_elt_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .slot        (slot),
  .found_value (found_value),
  .hits        (hits),
  .misses      (misses)
);

/* tb/elt_checker.sv */
`timescale 1ns / 1ps

module elt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] lookup_key,
  input  logic [31:0] new_value,
  input  logic [31:0] now,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [5:0]  slot,
  input  logic [31:0] found_value,
  input  logic [31:0] hits,
  input  logic [31:0] misses,
  output int          pending,
  output int          errors
);
  import elt_pkg::*;

  typedef struct {
    status_t     status;
    logic [5:0]  slot;
    logic [31:0] found_value;
    logic [31:0] hits;
    logic [31:0] misses;
  } reply_t;

  // Shadow copy of the table.
  bit          live  [ENTRIES];
  bit          held  [ENTRIES];
  time_t       stamp [ENTRIES];
  key_t        tag   [ENTRIES];
  val_t        store [ENTRIES];
  logic [31:0] get_hits;
  logic [31:0] get_misses;
  logic [31:0] lifetime;

  reply_t table_replies [$];
  int     reply_no;

  initial begin
    pending  = 0;
    errors   = 0;
    reply_no = 0;
  end

  task automatic report(string msg);
    if (errors < 50)
      $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  function automatic time_t age_of(int i);
    return held[i] ? RESERVED_TIME : stamp[i];
  endfunction

  // 33-bit sum, so a long lifetime never wraps into the past.
  function automatic bit has_lapsed(int i, time_t t_now);
    logic [32:0] due;
    due = {1'b0, age_of(i)} + {1'b0, lifetime};
    return due <= {1'b0, t_now};
  endfunction

  function automatic reply_t table_update(logic [2:0] code, logic [31:0] k32,
                                          logic [31:0] v32, time_t t_now);
    reply_t r;
    key_t   k;
    val_t   v;
    int     hit_idx;
    int     tgt;
    bit     have;
    k = k32[KEY_W-1:0];
    v = v32[VAL_W-1:0];
    r.status      = ST_MISS;
    r.slot        = '0;
    r.found_value = '0;
    hit_idx = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit_idx < 0 && live[i] && tag[i] == k) hit_idx = i;

    case (code)
      CMD_PUT, CMD_PUT_RES: begin
        have = 1'b0;
        tgt  = -1;
        if (hit_idx >= 0) begin
          tgt  = hit_idx;
          have = 1'b1;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (tgt < 0 && !live[i]) tgt = i;
          if (tgt >= 0) begin
            have = 1'b1;
          end else begin
            // Oldest entry, lowest index on a tie; evict only once it lapsed.
            tgt = 0;
            for (int i = 1; i < ENTRIES; i++)
              if (age_of(tgt) > age_of(i)) tgt = i;
            have = has_lapsed(tgt, t_now);
          end
        end
        if (have) begin
          if (!live[tgt]) held[tgt] = 1'b0;
          if (!held[tgt]) begin
            if (code == CMD_PUT_RES) held[tgt] = 1'b1;
            else stamp[tgt] = t_now;
          end
          live[tgt]  = 1'b1;
          tag[tgt]   = k;
          store[tgt] = v;
          r.status   = ST_OK;
          r.slot     = 6'(tgt);
          r.found_value[VAL_W-1:0] = v;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_GET: begin
        if (hit_idx >= 0 && (lifetime == 0 || !has_lapsed(hit_idx, t_now))) begin
          if (!held[hit_idx]) stamp[hit_idx] = t_now;
          get_hits = get_hits + 1;
          r.status  = ST_OK;
          r.slot    = 6'(hit_idx);
          r.found_value[VAL_W-1:0] = store[hit_idx];
        end else begin
          get_misses = get_misses + 1;
        end
      end
      CMD_REFRESH, CMD_RESERVE, CMD_RESET_TIME, CMD_REMOVE: begin
        if (hit_idx >= 0) begin
          if (code == CMD_REFRESH || code == CMD_RESET_TIME) begin
            stamp[hit_idx] = t_now;
            held[hit_idx]  = 1'b0;
          end else if (code == CMD_RESERVE) begin
            held[hit_idx] = 1'b1;
          end else begin
            live[hit_idx] = 1'b0;
            held[hit_idx] = 1'b0;
          end
          r.status = ST_OK;
          r.slot   = 6'(hit_idx);
        end
      end
      default: ;
    endcase
    r.hits   = get_hits;
    r.misses = get_misses;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        live[i] = 1'b0;
        held[i] = 1'b0;
      end
      get_hits   = '0;
      get_misses = '0;
      lifetime   = '0;
      table_replies.delete();
    end else begin
      if (cfg_write) lifetime = cfg_data;
      if (out_valid && !out_stall) begin
        if (table_replies.size() == 0) begin
          report($sformatf("reply %0d arrived with no request pending", reply_no));
        end else begin
          want = table_replies.pop_front();
          if (status !== want.status)
            report($sformatf("reply %0d status: got %0d, want %0d",
                             reply_no, status, want.status));
          if (slot !== want.slot)
            report($sformatf("reply %0d slot: got %0d, want %0d",
                             reply_no, slot, want.slot));
          if (found_value !== want.found_value)
            report($sformatf("reply %0d found_value: got %h, want %h",
                             reply_no, found_value, want.found_value));
          if (hits !== want.hits)
            report($sformatf("reply %0d hits: got %0d, want %0d",
                             reply_no, hits, want.hits));
          if (misses !== want.misses)
            report($sformatf("reply %0d misses: got %0d, want %0d",
                             reply_no, misses, want.misses));
        end
        reply_no++;
      end
      if (in_valid && !in_stall)
        table_replies.push_back(table_update(command, lookup_key, new_value, now));
    end
    pending = table_replies.size();
  end

endmodule

/* tb/tb_expiring_lru_table.sv */
`timescale 1ns / 1ps

module tb_expiring_lru_table;
  import elt_pkg::*;

  // Each request streams every entry of the table, so a thousand requests with
  // heavy stalling stay far below this ceiling.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = ENTRIES + 16;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [2:0]  command   = CMD_PUT;
  logic [31:0] lookup_key = '0;
  logic [31:0] new_value  = '0;
  logic [31:0] now        = '0;
  logic        out_stall  = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [5:0]  slot;
  logic [31:0] found_value;
  logic [31:0] hits;
  logic [31:0] misses;

  int pending;
  int mismatches;
  int cycle_count = 0;

  // Idle rates in percent, switched per phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #2 clk = ~clk;

  expiring_lru_table u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .lookup_key  (lookup_key),
    .new_value   (new_value),
    .now         (now),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot        (slot),
    .found_value (found_value),
    .hits        (hits),
    .misses      (misses)
  );

  elt_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .lookup_key  (lookup_key),
    .new_value   (new_value),
    .now         (now),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot        (slot),
    .found_value (found_value),
    .hits        (hits),
    .misses      (misses),
    .pending     (pending),
    .errors      (mismatches)
  );

  // Stall the result side at the current phase's rate; keep it open in reset.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one request at a falling edge and hold it until accepted.
  // Random idle cycles before it drop valid; valid stays high between
  // back-to-back requests so it is never lowered and raised in one step.
  task automatic issue(cmd_t c, logic [31:0] k, logic [31:0] v, time_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= c;
    lookup_key <= k;
    new_value  <= v;
    now        <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted reply has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Change the lifetime only while the table is idle.
  task automatic set_lifetime(logic [31:0] secs);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= secs;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random traffic over a pool of keys a bit larger than the table, so the
  // table fills up and puts go through eviction and the table-full path.
  // Time mostly creeps forward from t0 with an occasional random jump.
  task automatic run_phase(int n_items, int pool_n, time_t t0, int step);
    logic [31:0] pool [128];
    time_t       clock_s;
    time_t       t;
    logic [31:0] k;
    cmd_t        c;
    int          p;
    for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
    clock_s = t0;
    for (int n = 0; n < n_items; n++) begin
      // Occasionally let the table drain completely before the next request.
      if ($urandom_range(0, 99) < 2) wait_drained();
      p = $urandom_range(0, 99);
      if (p < 38)      c = CMD_PUT;
      else if (p < 46) c = CMD_PUT_RES;
      else if (p < 74) c = CMD_GET;
      else if (p < 80) c = CMD_REFRESH;
      else if (p < 85) c = CMD_RESERVE;
      else if (p < 90) c = CMD_RESET_TIME;
      else             c = CMD_REMOVE;
      if ($urandom_range(0, 99) < 8) k = $urandom;
      else k = pool[$urandom_range(0, pool_n - 1)];
      clock_s = clock_s + time_t'($urandom_range(0, step));
      if ($urandom_range(0, 99) < 5) t = $urandom;
      else t = clock_s;
      issue(c, k, $urandom, t);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests, lifetime still at its reset value of zero.
    issue(CMD_GET,        32'h0000_0000, 32'h0000_0000, 32'h0000_0000); // miss on empty
    issue(CMD_PUT,        32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    issue(CMD_PUT,        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    issue(CMD_GET,        32'h0000_0000, 32'h1111_1111, 32'h0000_0007); // no expiry at 0
    issue(CMD_GET,        32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
    issue(CMD_PUT_RES,    32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'h0000_000a);
    issue(CMD_GET,        32'ha5a5_a5a5, 32'h0000_0000, 32'h0000_000c); // reserved hit
    issue(CMD_PUT,        32'ha5a5_a5a5, 32'h0000_0001, 32'h0000_000d); // stays reserved
    issue(CMD_REFRESH,    32'ha5a5_a5a5, 32'h0000_0000, 32'h0000_000e);
    issue(CMD_RESERVE,    32'h0000_0000, 32'h0000_0000, 32'h0000_000f);
    issue(CMD_RESET_TIME, 32'h0000_0000, 32'h0000_0000, 32'h0000_0010);
    issue(CMD_REMOVE,     32'hffff_ffff, 32'h0000_0000, 32'h0000_0011);
    issue(CMD_GET,        32'hffff_ffff, 32'h0000_0000, 32'h0000_0012); // removed
    issue(CMD_REFRESH,    32'h0000_0012, 32'h0000_0000, 32'h0000_0013); // not found
    issue(CMD_RESERVE,    32'h0000_0012, 32'h0000_0000, 32'h0000_0013);
    issue(CMD_RESET_TIME, 32'h0000_0012, 32'h0000_0000, 32'h0000_0013);
    issue(CMD_REMOVE,     32'h0000_0012, 32'h0000_0000, 32'h0000_0013);

    // Short lifetime: live hit, then the same key one lifetime later.
    set_lifetime(32'd10);
    issue(CMD_PUT,        32'h0000_0033, 32'hdead_beef, 32'd100);
    issue(CMD_GET,        32'h0000_0033, 32'h0000_0000, 32'd109);
    issue(CMD_GET,        32'h0000_0033, 32'h0000_0000, 32'd119);   // expired get
    issue(CMD_PUT_RES,    32'h0000_0044, 32'hcafe_f00d, 32'd120);
    issue(CMD_GET,        32'h0000_0044, 32'h0000_0000, 32'hff00_000a); // reserved lapsed
    issue(CMD_GET,        32'h0000_0044, 32'h0000_0000, 32'hff00_0009);

    // Longest lifetime: the time sum must not wrap around.
    set_lifetime(32'hffff_ffff);
    issue(CMD_GET,        32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);

    // Random phases: lifetime, idle pattern, count, key pool, start, step.
    set_lifetime(32'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(170, 90, 32'd1000, 3);

    set_lifetime(32'd40);
    send_idle_pct  = 58;
    recv_stall_pct = 0;
    run_phase(170, 100, 32'd5000, 2);

    set_lifetime(32'hffff_ffff);
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    run_phase(150, 80, 32'hffff_ff00, 1);

    set_lifetime(32'd1);
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_phase(170, 72, 32'd200, 2);

    // Walk time across the reserved mark so reserved entries can lapse.
    set_lifetime(32'd25);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(170, 100, 32'hfeff_ff80, 2);

    set_lifetime(32'h7fff_ffff);
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_phase(150, 90, 32'h8000_0000, 500);

    // Drain, then watch a while longer for stray replies.
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
